@@ rtl/core/rre_pkg.sv @@
// Shared constants, phase codes and controller/datapath interface types for the ramp envelope.
package rre_pkg;

	localparam int TimeW   = 32;
	localparam int LevelW  = 8;
	localparam int PhaseW  = 2;
	localparam int CfgIdxW = 2;
	localparam int DivSteps = LevelW;
	localparam int DivCntW  = $clog2(DivSteps);

	localparam logic [LevelW-1:0] FullLevel = 8'd255;

	// envelope phase codes as seen on the result channel
	localparam logic [PhaseW-1:0] PH_IDLE = 2'd0;
	localparam logic [PhaseW-1:0] PH_RISE = 2'd1;
	localparam logic [PhaseW-1:0] PH_HOLD = 2'd2;
	localparam logic [PhaseW-1:0] PH_FALL = 2'd3;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_RISE = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_HOLD = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_FALL = 2'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_in;
		logic eval;
		logic trig_a;
		logic trig_b;
		logic trig_c;
		logic prep;
		logic mult;
		logic div_step;
		logic load_out;
	} rre_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic trig;
		logic ramp;
	} rre_stat_t;

endpackage

@@ rtl/core/retriggerable_ramp_envelope.sv @@
// Top level of the retriggerable attack-hold-release ramp envelope.
// Each item (opcode, now_time) yields one result (level, phase, active) for
// the ramp state after the item. Items are taken one at a time. After an
// item is accepted its timestamp is evaluated; a trigger first updates the
// ramp timestamps and then evaluates the timestamp again. A sample outside
// any ramp segment goes straight to the result; a sample on the rising or
// falling segment first passes the prepare, multiply and divide steps. The
// result is loaded once the output is free, and the next item can be taken
// in the cycle after the result is loaded. The rising and falling levels come
// from a shared restoring divider that produces one quotient bit per cycle.
// The result sits in an output register, so a finished result may wait on
// out_stall while the next item is already being accepted.
// Configuration writes take effect at once and are meant for idle periods.
module retriggerable_ramp_envelope import rre_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [TimeW-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic [TimeW-1:0]   now_time,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [LevelW-1:0]  level,
	output logic [PhaseW-1:0]  phase,
	output logic               active
);

	rre_cmd_t  cmd;
	rre_stat_t stat;

	// sequence each item
	rre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// compute timestamps and level
	rre_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.opcode    (opcode),
		.now_time  (now_time),
		.cmd       (cmd),
		.stat      (stat),
		.level     (level),
		.phase     (phase),
		.active    (active)
	);

endmodule

@@ rtl/core/rre_dp.sv @@
// Datapath: config registers, ramp timestamps, phase evaluation, divider and result register.
module rre_dp import rre_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [TimeW-1:0]    cfg_data,
	input  logic                opcode,
	input  logic [TimeW-1:0]    now_time,
	input  rre_cmd_t            cmd,
	output rre_stat_t           stat,
	output logic [LevelW-1:0]   level,
	output logic [PhaseW-1:0]   phase,
	output logic                active
);

	logic [TimeW-1:0] rise_time_q, hold_time_q, fall_time_q;
	logic [TimeW-1:0] ramp_start_q, rise_end_q, hold_end_q, fall_end_q;
	logic             started_q;
	logic             trig_q;
	logic [TimeW-1:0] now_q;
	logic [PhaseW-1:0] phase_q;
	logic             act_q;
	logic [TimeW-1:0] elapsed_q, span_q;
	logic [TimeW-1:0] rem_q;
	logic [LevelW-1:0] quo_q;
	logic [LevelW-1:0] level_q;
	logic [PhaseW-1:0] phase_out_q;
	logic             active_out_q;

	logic              act_c;
	logic [PhaseW-1:0] phase_c;
	logic [TimeW-1:0]  from_c, to_c, hold_base_c;
	logic [TimeW+LevelW-1:0] num_c;
	logic [TimeW:0]    trial_c;
	logic              fit_c;
	logic [TimeW:0]    diff_c;
	logic [LevelW-1:0] level_c;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_time_q <= '0;
			hold_time_q <= '0;
			fall_time_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RISE: rise_time_q <= cfg_data;
				CFG_HOLD: hold_time_q <= cfg_data;
				CFG_FALL: fall_time_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify the latched timestamp against the current ramp
	always_comb begin
		act_c = started_q && (now_q >= ramp_start_q) && (now_q <= fall_end_q);
		if (!act_c)
			phase_c = PH_IDLE;
		else if (now_q < rise_end_q)
			phase_c = PH_RISE;
		else if (now_q < hold_end_q)
			phase_c = PH_HOLD;
		else if (now_q < fall_end_q)
			phase_c = PH_FALL;
		else
			phase_c = PH_IDLE;
	end

	// pick the ramp segment and form the scaled numerator
	always_comb begin
		from_c      = (phase_q == PH_RISE) ? ramp_start_q : hold_end_q;
		to_c        = (phase_q == PH_RISE) ? rise_end_q : fall_end_q;
		hold_base_c = (phase_q == PH_HOLD) ? now_q : rise_end_q;
		num_c       = {elapsed_q, {LevelW{1'b0}}} - {{LevelW{1'b0}}, elapsed_q};
		trial_c     = {rem_q, quo_q[LevelW-1]};
		diff_c      = trial_c - {1'b0, span_q};
		fit_c       = (trial_c >= {1'b0, span_q});
	end

	// map phase and quotient to the output level
	always_comb begin
		case (phase_q)
			PH_RISE: level_c = quo_q;
			PH_HOLD: level_c = FullLevel;
			PH_FALL: level_c = FullLevel - quo_q;
			default: level_c = '0;
		endcase
	end

	// started flag and pending trigger are control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			trig_q    <= 1'b0;
		end else begin
			if (cmd.load_in)
				trig_q <= opcode;
			else if (cmd.trig_c)
				trig_q <= 1'b0;
			if (cmd.trig_a && (phase_q == PH_IDLE))
				started_q <= 1'b1;
		end
	end

	// advance timestamps, phase, divider and result registers
	always_ff @(posedge clk) begin
		if (cmd.load_in)
			now_q <= now_time;
		if (cmd.eval) begin
			phase_q <= phase_c;
			act_q   <= act_c;
		end
		// restart or rewind the ramp start
		if (cmd.trig_a) begin
			if (phase_q == PH_IDLE) begin
				ramp_start_q <= now_q;
				rise_end_q   <= now_q + rise_time_q;
			end else if (phase_q == PH_FALL) begin
				ramp_start_q <= now_q - rise_time_q;
				rise_end_q   <= now_q;
			end
		end
		if (cmd.trig_b)
			hold_end_q <= hold_base_c + hold_time_q;
		if (cmd.trig_c)
			fall_end_q <= hold_end_q + fall_time_q;
		if (cmd.prep) begin
			elapsed_q <= now_q - from_c;
			span_q    <= to_c - from_c;
		end
		if (cmd.mult) begin
			rem_q <= num_c[TimeW+LevelW-1:LevelW];
			quo_q <= num_c[LevelW-1:0];
		end
		// one restoring step per cycle
		if (cmd.div_step) begin
			rem_q <= fit_c ? diff_c[TimeW-1:0] : trial_c[TimeW-1:0];
			quo_q <= {quo_q[LevelW-2:0], fit_c};
		end
		if (cmd.load_out) begin
			level_q      <= level_c;
			phase_out_q  <= phase_q;
			active_out_q <= act_q;
		end
	end

	assign stat.trig = trig_q;
	assign stat.ramp = (phase_q == PH_RISE) || (phase_q == PH_FALL);
	assign level     = level_q;
	assign phase     = phase_out_q;
	assign active    = active_out_q;

endmodule

@@ rtl/core/rre_ctrl.sv @@
// Controller: sequences trigger update, evaluation, division and result handoff.
module rre_ctrl import rre_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  rre_stat_t stat,
	output rre_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_ROUTE,
		ST_TRIG_A,
		ST_TRIG_B,
		ST_TRIG_C,
		ST_PREP,
		ST_MULT,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [DivCntW-1:0] cnt_q;
	logic               out_valid_q;
	logic               out_free;

	assign out_free = !out_valid_q || !out_stall;

	// decode commands from the state
	always_comb begin
		cmd          = '0;
		cmd.load_in  = (state_q == ST_IDLE) && in_valid;
		cmd.eval     = (state_q == ST_EVAL);
		cmd.trig_a   = (state_q == ST_TRIG_A);
		cmd.trig_b   = (state_q == ST_TRIG_B);
		cmd.trig_c   = (state_q == ST_TRIG_C);
		cmd.prep     = (state_q == ST_PREP);
		cmd.mult     = (state_q == ST_MULT);
		cmd.div_step = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

	// hold state, step count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:   if (in_valid) state_q <= ST_EVAL;
				ST_EVAL:   state_q <= ST_ROUTE;
				ST_ROUTE: begin
					if (stat.trig)
						state_q <= ST_TRIG_A;
					else if (stat.ramp)
						state_q <= ST_PREP;
					else
						state_q <= ST_DONE;
				end
				ST_TRIG_A: state_q <= ST_TRIG_B;
				ST_TRIG_B: state_q <= ST_TRIG_C;
				ST_TRIG_C: state_q <= ST_EVAL;
				ST_PREP:   state_q <= ST_MULT;
				ST_MULT: begin
					cnt_q   <= DivCntW'(DivSteps - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= ST_DONE;
				end
				ST_DONE:   if (out_free) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ rtl/core/rre_chk.sv @@
// Port-level checker for the ramp envelope, bound to the top level.
module rre_chk import rre_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [LevelW-1:0]  level,
	input logic [PhaseW-1:0]  phase,
	input logic               active
);

	// an inactive result reports the idle phase
	a_inactive_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !active |-> phase == PH_IDLE)
		else $error("inactive result with non-idle phase");

	// idle phase carries zero level
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == PH_IDLE |-> level == '0)
		else $error("idle phase with nonzero level");

	// plateau carries full level
	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == PH_HOLD |-> level == FullLevel)
		else $error("plateau below full level");

	// an accepted item keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// hold a stalled result unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			out_valid && $stable(level) && $stable(phase) && $stable(active))
		else $error("stalled result changed or dropped");

endmodule

bind retriggerable_ramp_envelope rre_chk u_rre_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.level     (level),
	.phase     (phase),
	.active    (active)
);
